>>> rtl/osp_pkg.sv
// Package of the ordered slot pool: sizes, request and status codes, key byte masks.
// Depends on nothing; osp_if and the core import it.
package osp_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int KEY_BYTES  = 8;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 4;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Slot index width and a position counter that can also hold SLOT_COUNT.
    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_W = KEY_W + HANDLE_W;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [POS_W-1:0] POS_COUNT = POS_W'(SLOT_COUNT);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(SLOT_COUNT - 1);

    localparam logic [MODE_W-1:0] MODE_DEPOSIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WITHDRAW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    // Mask covering the first len key bytes; lengths past KEY_BYTES saturate.
    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (LEN_W'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [KEY_W-1:0] KEY_MASK = byte_mask(LEN_W'(KEY_BYTES));

endpackage

>>> rtl/osp_if.sv
// Valid/ready channel interfaces for the request and result beats of the slot pool.
// Depends on osp_pkg for field widths.
interface osp_req_if
    import osp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle_in;
    logic [KEY_W-1:0]    key;
    logic [LEN_W-1:0]    key_len;

    modport source (output valid, mode, handle_in, key, key_len, input ready);
    modport sink   (input valid, mode, handle_in, key, key_len, output ready);
endinterface

interface osp_rsp_if
    import osp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;

    modport source (output valid, status, handle_out, input ready);
    modport sink   (input valid, status, handle_out, output ready);
endinterface

>>> rtl/osp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module osp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/ordered_slot_pool_with_key_lookup_core.sv
// Top level of the ordered slot pool with key lookup.
// Depends on osp_pkg, the osp_req_if/osp_rsp_if interfaces and the osp_ram memory.
//
// Requests arrive as beats on the req channel (mode, handle_in, key, key_len) and
// each one yields exactly one beat on the rsp channel (status, handle_out); a beat
// moves when valid and ready are both high at a rising edge of clk.
// One request is served at a time. The service order lives in one RAM and the slot
// contents in another; a request walks the order one position per cycle through a
// three-stage read pipeline (order RAM, slot RAM, compare). When the scan stops, the
// result is loaded into the output register. A withdraw first moves its slot to the
// tail, one order entry per cycle, before its result is loaded. A rejected request
// skips the scan and has its result loaded directly. req.ready rises again as the
// result is loaded into the output register. After rst_n is released the block
// writes the initial order and empties every slot; req.ready stays low during
// that pass. The result sits in an output register. A new request is taken while
// an earlier result waits there; if the receiver still stalls when the next result
// is done, the block holds that result and stays busy until the register frees up.
module ordered_slot_pool_with_key_lookup_core
    import osp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    osp_req_if.sink   req,
    osp_rsp_if.source rsp
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    // Request held for the whole operation.
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    mask_reg, mask_next;

    // Reset pass pointer.
    logic [IDX_W-1:0] init_ptr_reg, init_ptr_next;

    // Scan pipeline: stage A issues the order read, stage B the slot read,
    // stage C compares.
    logic [POS_W-1:0] pos_a_reg, pos_a_next;
    logic             vb_reg, vb_next;
    logic [POS_W-1:0] pos_b_reg, pos_b_next;
    logic             vc_reg, vc_next;
    logic [POS_W-1:0] pos_c_reg, pos_c_next;
    logic [IDX_W-1:0] s_c_reg, s_c_next;

    // Move-to-tail sweep.
    logic [POS_W-1:0] shift_rd_reg, shift_rd_next;
    logic             shift_wv_reg, shift_wv_next;
    logic [IDX_W-1:0] shift_wa_reg, shift_wa_next;
    logic [IDX_W-1:0] moved_reg, moved_next;

    // Result waiting for the output register, and the output register itself.
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;

    // Memory ports.
    logic             order_we;
    logic [IDX_W-1:0] order_waddr, order_raddr, order_wdata, order_rdata;
    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_wdata, slot_rdata;

    logic [HANDLE_W-1:0] rd_handle;
    logic [KEY_W-1:0]    rd_key;
    logic                occupied, key_match, hit, issue, rd_go, req_bad, accept;

    osp_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_order_ram (
        .clk   (clk),
        .we    (order_we),
        .waddr (order_waddr),
        .wdata (order_wdata),
        .raddr (order_raddr),
        .rdata (order_rdata)
    );

    osp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign req.ready      = (state_reg == ST_IDLE);
    assign accept         = req.valid && req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;

    // A slot is empty exactly when its stored handle is zero.
    assign rd_handle = slot_rdata[HANDLE_W-1:0];
    assign rd_key    = slot_rdata[SLOT_W-1:HANDLE_W];
    assign occupied  = (rd_handle != '0);
    assign key_match = (((rd_key ^ key_reg) & mask_reg) == '0);
    assign issue     = (pos_a_reg < POS_COUNT);
    assign rd_go     = (shift_rd_reg < POS_COUNT);

    // Requests rejected without touching the pool.
    assign req_bad = (req.mode == MODE_DEPOSIT &&
                      (req.handle_in == '0 || req.key_len == '0)) ||
                     (req.mode == MODE_LOOKUP && req.key_len == '0) ||
                     (req.mode != MODE_DEPOSIT && req.mode != MODE_WITHDRAW &&
                      req.mode != MODE_LOOKUP);

    always_comb
    begin
        case (mode_reg)
            MODE_DEPOSIT:  hit = !occupied;
            MODE_WITHDRAW: hit = occupied;
            MODE_LOOKUP:   hit = occupied && key_match;
            default:       hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        handle_next     = handle_reg;
        key_next        = key_reg;
        mask_next       = mask_reg;
        init_ptr_next   = init_ptr_reg;
        pos_a_next      = pos_a_reg;
        vb_next         = 1'b0;
        pos_b_next      = pos_a_reg;
        vc_next         = 1'b0;
        pos_c_next      = pos_b_reg;
        s_c_next        = order_rdata;
        shift_rd_next   = shift_rd_reg;
        shift_wv_next   = 1'b0;
        shift_wa_next   = shift_wa_reg;
        moved_next      = moved_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;

        order_we    = 1'b0;
        order_waddr = init_ptr_reg;
        order_wdata = init_ptr_reg;
        order_raddr = pos_a_reg[IDX_W-1:0];
        slot_we     = 1'b0;
        slot_waddr  = s_c_reg;
        slot_wdata  = {key_reg & mask_reg, handle_reg};
        slot_raddr  = order_rdata;

        case (state_reg)
            ST_INIT:
            begin
                // Position i holds slot i and every slot is empty.
                order_we    = 1'b1;
                slot_we     = 1'b1;
                slot_waddr  = init_ptr_reg;
                slot_wdata  = '0;
                init_ptr_next = init_ptr_reg + 1'b1;
                if (init_ptr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = req.mode;
                    handle_next = req.handle_in;
                    key_next    = req.key & KEY_MASK;
                    mask_next   = byte_mask(req.key_len);
                    pos_a_next  = '0;
                    if (req_bad)
                    begin
                        res_status_next = STATUS_INVALID;
                        res_handle_next = '0;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                vb_next = issue;
                if (issue)
                begin
                    pos_a_next = pos_a_reg + 1'b1;
                end
                vc_next = vb_reg;
                if (vc_reg && hit)
                begin
                    res_status_next = STATUS_OK;
                    state_next      = ST_FINISH;
                    case (mode_reg)
                        MODE_DEPOSIT:
                        begin
                            slot_we         = 1'b1;
                            res_handle_next = '0;
                        end
                        MODE_WITHDRAW:
                        begin
                            slot_we         = 1'b1;
                            slot_wdata      = {rd_key, {HANDLE_W{1'b0}}};
                            res_handle_next = rd_handle;
                            moved_next      = s_c_reg;
                            shift_rd_next   = pos_c_reg + 1'b1;
                            state_next      = ST_SHIFT;
                        end
                        default:
                        begin
                            res_handle_next = rd_handle;
                        end
                    endcase
                end
                else if (vc_reg && pos_c_reg == POS_LAST)
                begin
                    res_status_next = STATUS_MISS;
                    res_handle_next = '0;
                    state_next      = ST_FINISH;
                end
            end

            ST_SHIFT:
            begin
                // Each entry behind the withdrawn one moves up one position;
                // the withdrawn slot goes to the last position.
                order_raddr   = shift_rd_reg[IDX_W-1:0];
                shift_wv_next = rd_go;
                shift_wa_next = IDX_W'(shift_rd_reg - 1'b1);
                if (rd_go)
                begin
                    shift_rd_next = shift_rd_reg + 1'b1;
                end
                if (shift_wv_reg)
                begin
                    order_we    = 1'b1;
                    order_waddr = shift_wa_reg;
                    order_wdata = order_rdata;
                end
                else if (!rd_go)
                begin
                    order_we    = 1'b1;
                    order_waddr = LAST_IDX;
                    order_wdata = moved_reg;
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_ptr_reg  <= '0;
            pos_a_reg     <= '0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            shift_rd_reg  <= '0;
            shift_wv_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_ptr_reg  <= init_ptr_next;
            pos_a_reg     <= pos_a_next;
            vb_reg        <= vb_next;
            vc_reg        <= vc_next;
            shift_rd_reg  <= shift_rd_next;
            shift_wv_reg  <= shift_wv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        handle_reg     <= handle_next;
        key_reg        <= key_next;
        mask_reg       <= mask_next;
        pos_b_reg      <= pos_b_next;
        pos_c_reg      <= pos_c_next;
        s_c_reg        <= s_c_next;
        shift_wa_reg   <= shift_wa_next;
        moved_reg      <= moved_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end

    // The order must not change while a scan is reading it.
    a_no_order_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !order_we)
        else $error("order RAM written during a scan");

    // A slot write during a scan is the final action of that scan.
    a_slot_write_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_we && state_reg == ST_SCAN) |=> (state_reg != ST_SCAN))
        else $error("scan continued after a slot write");

    // A successful withdraw always hands out a nonzero handle.
    a_withdraw_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && mode_reg == MODE_WITHDRAW &&
         res_status_reg == STATUS_OK) |-> (res_handle_reg != '0))
        else $error("withdraw succeeded with a zero handle");

    // Only a successful withdraw or lookup carries a handle.
    a_handle_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STATUS_OK) |-> (rsp.handle_out == '0))
        else $error("handle returned with a failing status");

endmodule
